[hw/rtl/mrc_pkg.sv]
// Shared types and constants of the Modbus RTU response checker.
// Used by the front, back, command queue and top modules; depends on nothing.
package mrc_pkg;

    localparam int MAX_REGS_DEF = 16;
    localparam int CNT_W        = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_COUNT  = 2'd2;

    localparam logic [7:0]  FUNC_READ   = 8'h03;
    localparam logic [7:0]  FUNC_WRITE  = 8'h06;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam int          BYTE_BITS   = 8;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HEADER  = 3'd1,
        ST_COUNT   = 3'd2,
        ST_CRC     = 3'd3,
        ST_TIMEOUT = 3'd4
    } t_status;

    typedef struct packed {
        t_status          status;
        logic             is_read;
        logic [CNT_W-1:0] count;
        logic             bank;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    typedef enum logic {
        BK_IDLE,
        BK_READ
    } t_back_state;

endpackage

[hw/rtl/mrc_cmd_fifo.sv]
// Two-entry queue of frame commands between the front and the back part.
// Uses mrc_pkg for the command type.
module mrc_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mrc_pkg::t_cmd i_data,
    output logic          o_full,
    output logic          o_valid,
    output mrc_pkg::t_cmd o_data,
    input  logic          i_pop
);

    mrc_pkg::t_cmd r_ent [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_ent[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_wp] <= i_data;
        end
    end

endmodule

[hw/rtl/mrc_word_ram.sv]
// Register word memory, two banks of frame data, one write and one read port.
// Read data is registered; no package dependency.
module mrc_word_ram #(
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [15:0]       i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [15:0]       o_rdata
);

    logic [15:0] r_mem [1 << ADDR_W];
    logic [15:0] r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[hw/rtl/mrc_front.sv]
// Front part: configuration registers, byte parsing, CRC and word capture.
// Uses mrc_pkg; issues one command per frame end or timeout to the queue.
module mrc_front #(
    parameter int  MAX_REGS = mrc_pkg::MAX_REGS_DEF,
    localparam int IDX_W    = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1,
    localparam int RAM_AW   = IDX_W + 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mrc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mrc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_push,
    input  logic                           i_req_type,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_full,
    input  logic                           i_cmd_full,
    output logic                           o_cmd_push,
    output mrc_pkg::t_cmd                  o_cmd,
    output logic                           o_ram_we,
    output logic [RAM_AW-1:0]              o_ram_waddr,
    output logic [15:0]                    o_ram_wdata,
    input  mrc_pkg::t_release              i_release
);

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < mrc_pkg::BYTE_BITS; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ mrc_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    logic [7:0]              r_slave;
    logic                    r_wmode;
    logic [mrc_pkg::CNT_W-1:0] r_rcount;
    logic [5:0]              r_pos;
    logic [15:0]             r_crc;
    logic                    r_hdr_bad;
    logic                    r_cnt_bad;
    logic [7:0]              r_pend_hi;
    logic [7:0]              r_crc_lo;
    logic                    r_bank;
    logic [1:0]              r_busy;

    logic [5:0]              n_pos;
    logic [15:0]             n_crc;
    logic                    n_hdr_bad;
    logic                    n_cnt_bad;
    logic [7:0]              n_pend_hi;
    logic [7:0]              n_crc_lo;
    logic                    n_bank;

    logic                    accept;
    logic [mrc_pkg::CNT_W-1:0] cnt;
    logic [6:0]              frame_len;
    logic [6:0]              pos_p2;
    logic                    in_body;
    logic                    at_crc_lo;
    logic [mrc_pkg::CNT_W-1:0] widx;
    logic [15:0]             recv_crc;
    logic                    set_busy;

    assign o_full = i_cmd_full || r_busy[r_bank];
    assign accept = i_push && !o_full;

    always_comb begin
        if (r_rcount == '0) begin
            cnt = mrc_pkg::CNT_W'(1);
        end else if (r_rcount > mrc_pkg::CNT_W'(MAX_REGS)) begin
            cnt = mrc_pkg::CNT_W'(MAX_REGS);
        end else begin
            cnt = r_rcount;
        end
    end

    assign frame_len = r_wmode ? 7'd8 : 7'd5 + {1'b0, cnt, 1'b0};
    assign pos_p2    = {1'b0, r_pos} + 7'd2;
    assign in_body   = pos_p2 < frame_len;
    assign at_crc_lo = pos_p2 == frame_len;
    assign widx      = mrc_pkg::CNT_W'((r_pos - 6'd4) >> 1);
    assign recv_crc  = {i_rx_byte, r_crc_lo};

    assign o_ram_waddr = {r_bank, widx[IDX_W-1:0]};
    assign o_ram_wdata = {r_pend_hi, i_rx_byte};

    always_comb begin
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_hdr_bad  = r_hdr_bad;
        n_cnt_bad  = r_cnt_bad;
        n_pend_hi  = r_pend_hi;
        n_crc_lo   = r_crc_lo;
        n_bank     = r_bank;
        set_busy   = 1'b0;
        o_ram_we   = 1'b0;
        o_cmd_push = 1'b0;
        o_cmd      = '{status: mrc_pkg::ST_OK, is_read: 1'b0, count: cnt, bank: r_bank};

        if (accept) begin
            if (i_req_type) begin
                o_cmd_push    = 1'b1;
                o_cmd.status  = mrc_pkg::ST_TIMEOUT;
            end else if (in_body) begin
                n_crc = crc_feed(r_crc, i_rx_byte);
                n_pos = r_pos + 6'd1;
                if (r_pos == 6'd0) begin
                    if (i_rx_byte != r_slave) begin
                        n_hdr_bad = 1'b1;
                    end
                end else if (r_pos == 6'd1) begin
                    if (i_rx_byte != (r_wmode ? mrc_pkg::FUNC_WRITE : mrc_pkg::FUNC_READ)) begin
                        n_hdr_bad = 1'b1;
                    end
                end else if (!r_wmode) begin
                    if (r_pos == 6'd2) begin
                        if (i_rx_byte != {2'b00, cnt, 1'b0}) begin
                            n_cnt_bad = 1'b1;
                        end
                    end else if (r_pos[0]) begin
                        n_pend_hi = i_rx_byte;
                    end else if (widx < mrc_pkg::CNT_W'(MAX_REGS)) begin
                        o_ram_we = 1'b1;
                    end
                end
            end else if (at_crc_lo) begin
                n_crc_lo = i_rx_byte;
                n_pos    = r_pos + 6'd1;
            end else begin
                o_cmd_push = 1'b1;
                if (r_hdr_bad) begin
                    o_cmd.status = mrc_pkg::ST_HEADER;
                end else if (!r_wmode && r_cnt_bad) begin
                    o_cmd.status = mrc_pkg::ST_COUNT;
                end else if (recv_crc != r_crc) begin
                    o_cmd.status = mrc_pkg::ST_CRC;
                end else if (!r_wmode) begin
                    o_cmd.is_read = 1'b1;
                    set_busy      = 1'b1;
                    n_bank        = !r_bank;
                end
            end

            if (o_cmd_push) begin
                n_pos     = '0;
                n_crc     = mrc_pkg::CRC_INIT;
                n_hdr_bad = 1'b0;
                n_cnt_bad = 1'b0;
                n_pend_hi = '0;
                n_crc_lo  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave   <= 8'd1;
            r_wmode   <= 1'b0;
            r_rcount  <= mrc_pkg::CNT_W'(10);
            r_pos     <= '0;
            r_crc     <= mrc_pkg::CRC_INIT;
            r_hdr_bad <= 1'b0;
            r_cnt_bad <= 1'b0;
            r_pend_hi <= '0;
            r_crc_lo  <= '0;
            r_bank    <= 1'b0;
            r_busy    <= '0;
        end else begin
            r_pos     <= n_pos;
            r_crc     <= n_crc;
            r_hdr_bad <= n_hdr_bad;
            r_cnt_bad <= n_cnt_bad;
            r_pend_hi <= n_pend_hi;
            r_crc_lo  <= n_crc_lo;
            r_bank    <= n_bank;
            if (i_release.valid) begin
                r_busy[i_release.bank] <= 1'b0;
            end
            if (set_busy) begin
                r_busy[r_bank] <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mrc_pkg::CFG_SLAVE_ADDR: begin
                        r_slave <= i_cfg_data;
                    end
                    mrc_pkg::CFG_WRITE_MODE: begin
                        r_wmode <= i_cfg_data[0];
                    end
                    mrc_pkg::CFG_REG_COUNT: begin
                        r_rcount <= i_cfg_data[mrc_pkg::CNT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

[hw/rtl/mrc_back.sv]
// Back part: turns frame commands into result transactions, reading words from memory.
// Uses mrc_pkg; drives the output register seen on the result ports.
module mrc_back #(
    parameter int  MAX_REGS = mrc_pkg::MAX_REGS_DEF,
    localparam int IDX_W    = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1,
    localparam int RAM_AW   = IDX_W + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  mrc_pkg::t_cmd     i_cmd,
    output logic              o_cmd_pop,
    output logic              o_ram_re,
    output logic [RAM_AW-1:0] o_ram_raddr,
    input  logic [15:0]       i_ram_rdata,
    output mrc_pkg::t_release o_release,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [2:0]        o_status,
    output logic [3:0]        o_reg_index,
    output logic [15:0]       o_reg_value,
    output logic              o_last
);

    mrc_pkg::t_back_state      r_state;
    mrc_pkg::t_back_state      n_state;
    logic [IDX_W-1:0]          r_idx;
    logic [IDX_W-1:0]          n_idx;
    logic [mrc_pkg::CNT_W-1:0] r_cnt;
    logic [mrc_pkg::CNT_W-1:0] n_cnt;
    logic                      r_bank;
    logic                      n_bank;

    logic                      r_out_valid;
    logic                      n_out_valid;
    mrc_pkg::t_status          r_out_status;
    mrc_pkg::t_status          n_out_status;
    logic [3:0]                r_out_idx;
    logic [3:0]                n_out_idx;
    logic [15:0]               r_out_val;
    logic [15:0]               n_out_val;
    logic                      r_out_last;
    logic                      n_out_last;

    logic                      slot_free;
    logic                      word_last;

    assign o_empty     = !r_out_valid;
    assign o_status    = r_out_status;
    assign o_reg_index = r_out_idx;
    assign o_reg_value = r_out_val;
    assign o_last      = r_out_last;

    assign slot_free = !r_out_valid || i_pop;
    assign word_last = (mrc_pkg::CNT_W'(r_idx) + mrc_pkg::CNT_W'(1)) == r_cnt;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_bank       = r_bank;
        n_out_valid  = r_out_valid && !i_pop;
        n_out_status = r_out_status;
        n_out_idx    = r_out_idx;
        n_out_val    = r_out_val;
        n_out_last   = r_out_last;
        o_cmd_pop    = 1'b0;
        o_ram_re     = 1'b0;
        o_ram_raddr  = {r_bank, r_idx};
        o_release    = '{valid: 1'b0, bank: r_bank};

        unique case (r_state)
            mrc_pkg::BK_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.is_read) begin
                        o_cmd_pop   = 1'b1;
                        o_ram_re    = 1'b1;
                        o_ram_raddr = {i_cmd.bank, {IDX_W{1'b0}}};
                        n_idx       = '0;
                        n_cnt       = i_cmd.count;
                        n_bank      = i_cmd.bank;
                        n_state     = mrc_pkg::BK_READ;
                    end else if (slot_free) begin
                        o_cmd_pop    = 1'b1;
                        n_out_valid  = 1'b1;
                        n_out_status = i_cmd.status;
                        n_out_idx    = '0;
                        n_out_val    = '0;
                        n_out_last   = 1'b1;
                    end
                end
            end
            mrc_pkg::BK_READ: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = mrc_pkg::ST_OK;
                    n_out_idx    = 4'(r_idx);
                    n_out_val    = i_ram_rdata;
                    n_out_last   = word_last;
                    if (word_last) begin
                        o_release.valid = 1'b1;
                        n_state         = mrc_pkg::BK_IDLE;
                    end else begin
                        n_idx       = r_idx + IDX_W'(1);
                        o_ram_re    = 1'b1;
                        o_ram_raddr = {r_bank, n_idx};
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mrc_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_cnt        <= n_cnt;
        r_bank       <= n_bank;
        r_out_status <= n_out_status;
        r_out_idx    <= n_out_idx;
        r_out_val    <= n_out_val;
        r_out_last   <= n_out_last;
    end

endmodule

[hw/rtl/modbus_rtu_response_checker.sv]
// Top level of the Modbus RTU response checker: front, command queue, word memory, back.
// Depends on mrc_pkg and the mrc_* modules.
//
// Input channel: push with i_req_type and i_rx_byte, refused while full is high. CRC,
// header and byte count checks run as bytes arrive, and read reply words are captured
// into one of two memory banks.
// Result channel: the oldest result sits on o_status, o_reg_index, o_reg_value and
// o_last while empty is low, and pop takes it. An error, timeout or write echo gives one
// result, passed through the command queue and then the output register. A good read
// reply gives its words one per cycle while pop keeps the output free; the first passes
// through the command queue, the memory's registered read port and the output register.
// full is high while the two-entry command queue is full or while the bank the next frame
// would fill still holds words waiting to be delivered; a stalled receiver thus holds back
// the input once both banks and the queue are taken. Nothing is lost while stalled.
// Configuration writes through i_cfg_we, i_cfg_index and i_cfg_data take effect on the
// next cycle. Reset clears frame state, empties the queue and sets the registers to
// address 1, read mode and ten registers; there is no clearing pass.
module modbus_rtu_response_checker #(
    parameter int MAX_REGS = mrc_pkg::MAX_REGS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mrc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mrc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic                           i_req_type,
    input  logic [7:0]                     i_rx_byte,
    output logic                           empty,
    input  logic                           pop,
    output logic [2:0]                     o_status,
    output logic [3:0]                     o_reg_index,
    output logic [15:0]                    o_reg_value,
    output logic                           o_last
);

    localparam int IDX_W  = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
    localparam int RAM_AW = IDX_W + 1;

    logic              cmd_full;
    logic              cmd_push;
    mrc_pkg::t_cmd     cmd_in;
    logic              cmd_valid;
    mrc_pkg::t_cmd     cmd_out;
    logic              cmd_pop;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic              ram_re;
    logic [RAM_AW-1:0] ram_raddr;
    logic [15:0]       ram_rdata;
    mrc_pkg::t_release release_bank;

    mrc_front #(
        .MAX_REGS (MAX_REGS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_req_type  (i_req_type),
        .i_rx_byte   (i_rx_byte),
        .o_full      (full),
        .i_cmd_full  (cmd_full),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .i_release   (release_bank)
    );

    mrc_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .o_valid (cmd_valid),
        .o_data  (cmd_out),
        .i_pop   (cmd_pop)
    );

    mrc_word_ram #(
        .ADDR_W (RAM_AW)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mrc_back #(
        .MAX_REGS (MAX_REGS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_release   (release_bank),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_status    (o_status),
        .o_reg_index (o_reg_index),
        .o_reg_value (o_reg_value),
        .o_last      (o_last)
    );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the Modbus RTU response checker: directed frames from a table,
// then random read and write replies checked against an in-bench frame predictor.
// Depends on mrc_pkg and the modbus_rtu_response_checker RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_NS        = 4_000_000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 41;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        mrc_pkg::t_status status;
        logic [3:0]       idx;
        logic [15:0]      value;
        logic             last;
    } t_result;

    typedef enum logic [2:0] {
        B_LIT,
        B_CRC_LO,
        B_CRC_HI,
        B_CRC_BAD,
        B_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic             req;
        logic [7:0]       val;
        logic [4:0]       regs;
        logic             typed;
        mrc_pkg::t_status st;
    } t_row;

    localparam t_row DIRECTED[32] = '{
        '{B_LIT,     1'b1, 8'h00, 5'd0, 1'b1, mrc_pkg::ST_TIMEOUT},
        '{B_CFG,     1'b0, 8'h01, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_LIT,     1'b0, 8'h01, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_LIT,     1'b0, 8'h03, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_LIT,     1'b0, 8'h02, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_LIT,     1'b0, 8'hFF, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_LIT,     1'b0, 8'hFF, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_CRC_LO,  1'b0, 8'h00, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_CRC_HI,  1'b0, 8'h00, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_LIT,     1'b0, 8'h00, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_LIT,     1'b0, 8'h03, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_LIT,     1'b0, 8'h04, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_LIT,     1'b0, 8'h00, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_LIT,     1'b0, 8'h00, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_CRC_LO,  1'b0, 8'h00, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_CRC_BAD, 1'b0, 8'h00, 5'd0, 1'b1, mrc_pkg::ST_HEADER},
        '{B_LIT,     1'b0, 8'h01, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_LIT,     1'b0, 8'h03, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_LIT,     1'b0, 8'h04, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_LIT,     1'b0, 8'h00, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_LIT,     1'b0, 8'h00, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_CRC_LO,  1'b0, 8'h00, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_CRC_BAD, 1'b0, 8'h00, 5'd0, 1'b1, mrc_pkg::ST_COUNT},
        '{B_LIT,     1'b0, 8'h01, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_LIT,     1'b0, 8'h03, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_LIT,     1'b0, 8'h02, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_LIT,     1'b0, 8'h00, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_LIT,     1'b0, 8'h00, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_CRC_LO,  1'b0, 8'h00, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_CRC_BAD, 1'b0, 8'h00, 5'd0, 1'b1, mrc_pkg::ST_CRC},
        '{B_LIT,     1'b0, 8'h01, 5'd0, 1'b0, mrc_pkg::ST_OK},
        '{B_LIT,     1'b1, 8'hFF, 5'd0, 1'b1, mrc_pkg::ST_TIMEOUT}
    };

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [mrc_pkg::CFG_IDX_W-1:0]  i_cfg_index = mrc_pkg::CFG_SLAVE_ADDR;
    logic [mrc_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                           push        = 1'b0;
    logic                           full;
    logic                           i_req_type  = 1'b0;
    logic [7:0]                     i_rx_byte   = 8'h00;
    logic                           empty;
    logic                           pop         = 1'b0;
    logic [2:0]                     o_status;
    logic [3:0]                     o_reg_index;
    logic [15:0]                    o_reg_value;
    logic                           o_last;

    logic [7:0]  cfg_slave = 8'h01;
    logic        cfg_wmode = 1'b0;
    logic [4:0]  cfg_regs  = 5'd10;

    int          frm_pos     = 0;
    logic [15:0] frm_crc     = mrc_pkg::CRC_INIT;
    logic        frm_hdr_bad = 1'b0;
    logic        frm_cnt_bad = 1'b0;
    logic [7:0]  frm_hi      = 8'h00;
    logic [7:0]  frm_crc_lo  = 8'h00;
    logic [15:0] word_mem[mrc_pkg::MAX_REGS_DEF];

    t_result pending_results[$];
    int      n_errors        = 0;
    int      items_accepted  = 0;
    int      tx_idle_pct     = 0;
    int      rx_stall_pct    = 0;
    int      rx_hold_cycles  = 0;
    int      hold_left       = 0;

    modbus_rtu_response_checker u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_req_type  (i_req_type),
        .i_rx_byte   (i_rx_byte),
        .empty       (empty),
        .pop         (pop),
        .o_status    (o_status),
        .o_reg_index (o_reg_index),
        .o_reg_value (o_reg_value),
        .o_last      (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int k = 0; k < mrc_pkg::BYTE_BITS; k++) begin
            x = x[0] ? ((x >> 1) ^ mrc_pkg::CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    function automatic int eff_regs();
        if (cfg_regs == 5'd0) begin
            return 1;
        end
        return (cfg_regs > mrc_pkg::MAX_REGS_DEF) ? mrc_pkg::MAX_REGS_DEF : int'(cfg_regs);
    endfunction

    function automatic logic [7:0] rand_byte();
        unique case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void frame_clear();
        frm_pos     = 0;
        frm_crc     = mrc_pkg::CRC_INIT;
        frm_hdr_bad = 1'b0;
        frm_cnt_bad = 1'b0;
        frm_hi      = 8'h00;
        frm_crc_lo  = 8'h00;
    endfunction

    task automatic predict_response(input logic req, input logic [7:0] b,
                                    output t_result res[$]);
        int          n;
        int          len;
        int          pos;
        logic [15:0] rx_crc;
        res = {};
        if (req) begin
            res.push_back('{mrc_pkg::ST_TIMEOUT, 4'd0, 16'd0, 1'b1});
            frame_clear();
            return;
        end
        n   = eff_regs();
        len = cfg_wmode ? 8 : 5 + 2 * n;
        pos = frm_pos;
        if (pos + 2 < len) begin
            frm_crc = crc16_byte(frm_crc, b);
            if (pos == 0) begin
                if (b != cfg_slave) frm_hdr_bad = 1'b1;
            end else if (pos == 1) begin
                if (b != (cfg_wmode ? mrc_pkg::FUNC_WRITE : mrc_pkg::FUNC_READ)) begin
                    frm_hdr_bad = 1'b1;
                end
            end else if (!cfg_wmode) begin
                if (pos == 2) begin
                    if (b != 8'(2 * n)) frm_cnt_bad = 1'b1;
                end else if (pos % 2 == 1) begin
                    frm_hi = b;
                end else begin
                    word_mem[(pos - 4) / 2] = {frm_hi, b};
                end
            end
            frm_pos = pos + 1;
        end else if (pos + 2 == len) begin
            frm_crc_lo = b;
            frm_pos    = pos + 1;
        end else begin
            rx_crc = {b, frm_crc_lo};
            if (frm_hdr_bad) begin
                res.push_back('{mrc_pkg::ST_HEADER, 4'd0, 16'd0, 1'b1});
            end else if (!cfg_wmode && frm_cnt_bad) begin
                res.push_back('{mrc_pkg::ST_COUNT, 4'd0, 16'd0, 1'b1});
            end else if (rx_crc != frm_crc) begin
                res.push_back('{mrc_pkg::ST_CRC, 4'd0, 16'd0, 1'b1});
            end else if (cfg_wmode) begin
                res.push_back('{mrc_pkg::ST_OK, 4'd0, 16'd0, 1'b1});
            end else begin
                for (int i = 0; i < n; i++) begin
                    res.push_back('{mrc_pkg::ST_OK, 4'(i), word_mem[i], (i == n - 1)});
                end
            end
            frame_clear();
        end
    endtask

    task automatic send_item(input logic req, input logic [7:0] b,
                             input logic typed, input mrc_pkg::t_status st);
        t_result res[$];
        if ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        push       <= 1'b1;
        i_req_type <= req;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (full);
        items_accepted++;
        predict_response(req, b, res);
        if (typed) begin
            pending_results.push_back('{st, 4'd0, 16'd0, 1'b1});
        end else begin
            foreach (res[i]) pending_results.push_back(res[i]);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [7:0] addr, input logic wm, input logic [4:0] regs);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= mrc_pkg::CFG_SLAVE_ADDR;
        i_cfg_data  <= addr;
        @(posedge i_clk);
        i_cfg_index <= mrc_pkg::CFG_WRITE_MODE;
        i_cfg_data  <= {7'd0, wm};
        @(posedge i_clk);
        i_cfg_index <= mrc_pkg::CFG_REG_COUNT;
        i_cfg_data  <= {3'd0, regs};
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        cfg_slave = addr;
        cfg_wmode = wm;
        cfg_regs  = regs;
    endtask

    task automatic send_frame();
        int         n;
        int         len;
        int         cut;
        int         fault;
        logic       bad_addr;
        logic       bad_func;
        logic       bad_cnt;
        logic       bad_crc;
        logic       noise;
        logic       crc_lo_side;
        logic [7:0] flip;
        logic [7:0] b;
        n           = eff_regs();
        len         = cfg_wmode ? 8 : 5 + 2 * n;
        fault       = $urandom_range(99);
        bad_addr    = (fault >= 64 && fault < 70);
        bad_func    = (fault >= 70 && fault < 75);
        bad_cnt     = (fault >= 75 && fault < 80) && !cfg_wmode;
        bad_crc     = (fault >= 80 && fault < 86) || ((fault >= 75 && fault < 80) && cfg_wmode);
        noise       = (fault >= 86 && fault < 92);
        cut         = (fault >= 92) ? $urandom_range(len - 1) : len;
        crc_lo_side = $urandom_range(1);
        flip        = 8'($urandom_range(1, 255));
        for (int k = 0; k < cut; k++) begin
            if (noise) begin
                b = rand_byte();
            end else if (k == 0) begin
                b = bad_addr ? cfg_slave ^ 8'(1 << $urandom_range(7)) : cfg_slave;
            end else if (k == 1) begin
                b = (cfg_wmode ? mrc_pkg::FUNC_WRITE : mrc_pkg::FUNC_READ) ^
                    (bad_func ? flip : 8'h00);
            end else if (k == 2 && !cfg_wmode) begin
                b = 8'(2 * n) ^ (bad_cnt ? flip : 8'h00);
            end else if (k == len - 2) begin
                b = frm_crc[7:0] ^ ((bad_crc && crc_lo_side) ? flip : 8'h00);
            end else if (k == len - 1) begin
                b = frm_crc[15:8] ^ ((bad_crc && !crc_lo_side) ? flip : 8'h00);
            end else begin
                b = rand_byte();
            end
            send_item(1'b0, b, 1'b0, mrc_pkg::ST_OK);
        end
        if (cut < len) begin
            send_item(1'b1, rand_byte(), 1'b0, mrc_pkg::ST_OK);
        end
    endtask

    task automatic check_result();
        t_result want;
        if (pending_results.size() == 0) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
                $display("ERROR @%0t: unexpected result st=%0d idx=%0d val=%h last=%0b",
                         $time, o_status, o_reg_index, o_reg_value, o_last);
            end
            return;
        end
        want = pending_results.pop_front();
        if (o_status !== want.status || o_reg_index !== want.idx ||
            o_reg_value !== want.value || o_last !== want.last) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
                $display({"ERROR @%0t: expected st=%0d idx=%0d val=%h last=%0b, ",
                          "got st=%0d idx=%0d val=%h last=%0b"},
                         $time, want.status, want.idx, want.value, want.last,
                         o_status, o_reg_index, o_reg_value, o_last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) check_result();
            if (rx_hold_cycles > 0) begin
                hold_left      = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("modbus_rtu_response_checker: mismatch");
        $finish;
    end

    initial begin
        t_row row;
        int   phase_start;
        foreach (word_mem[i]) word_mem[i] = 16'h0000;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[r]) begin
            row = DIRECTED[r];
            unique case (row.kind)
                B_CFG: begin
                    wait_drained();
                    program_regs(row.val, row.req, row.regs);
                end
                B_CRC_LO:  send_item(1'b0, frm_crc[7:0], row.typed, row.st);
                B_CRC_HI:  send_item(1'b0, frm_crc[15:8], row.typed, row.st);
                B_CRC_BAD: send_item(1'b0, ~frm_crc[15:8], row.typed, row.st);
                default:   send_item(row.req, row.val, row.typed, row.st);
            endcase
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            unique case (ph)
                0: program_regs(8'h00, 1'b0, 5'd1);
                1: program_regs(8'hFF, 1'b1, 5'd16);
                2: program_regs(8'($urandom), 1'b0, 5'd16);
                3: program_regs(8'($urandom), 1'b0, 5'd31);
                4: program_regs(8'($urandom), 1'b1, 5'($urandom));
                5: program_regs(8'($urandom), 1'b0, 5'($urandom_range(2, 15)));
                6: program_regs(8'hFF, 1'b0, 5'd0);
                default: program_regs(8'($urandom), 1'($urandom), 5'($urandom));
            endcase
            unique case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 58; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 58; end
                default: begin tx_idle_pct = 31; rx_stall_pct = 31; end
            endcase
            // Hold the result side off while bytes keep coming, so the block backs up.
            if (ph == 2) rx_hold_cycles = 250;
            phase_start = items_accepted;
            while (items_accepted - phase_start < ITEMS_PER_PHASE) send_frame();
        end

        wait_drained();
        if (n_errors == 0) begin
            $display("modbus_rtu_response_checker: match");
        end else begin
            $display("modbus_rtu_response_checker: mismatch");
        end
        $finish;
    end

endmodule
